@@ rtl/ttip_pkg.sv @@
// Package for the text-to-integer parser: mode codes, status codes,
// per-string state type and the per-mode digit-count limit.
// No dependencies.
package ttip_pkg;

  localparam logic [2:0] MODE_SDEC64 = 3'd0;
  localparam logic [2:0] MODE_UDEC64 = 3'd1;
  localparam logic [2:0] MODE_HEX64  = 3'd2;
  localparam logic [2:0] MODE_OCT64  = 3'd3;
  localparam logic [2:0] MODE_SDEC32 = 3'd4;

  localparam int          ACC_W     = 64;
  localparam int          WIDE_W    = ACC_W + 4;
  localparam logic [4:0]  COUNT_MAX = 5'd31;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic [ACC_W-1:0] acc;
    logic [4:0]       count;
    status_t          err;
    logic             neg;
    logic             start;
  } ttip_state_t;

  localparam ttip_state_t STATE_CLEAR = '{
    acc:   '0,
    count: 5'd0,
    err:   ST_OK,
    neg:   1'b0,
    start: 1'b1
  };

  function automatic logic [4:0] mode_limit(input logic [2:0] mode);
    logic [4:0] lim;
    unique case (mode)
      MODE_SDEC64: lim = 5'd19;
      MODE_UDEC64: lim = 5'd20;
      MODE_HEX64:  lim = 5'd16;
      MODE_OCT64:  lim = 5'd22;
      MODE_SDEC32: lim = 5'd10;
      default:     lim = COUNT_MAX;
    endcase
    return lim;
  endfunction

  function automatic logic mode_signed(input logic [2:0] mode);
    return (mode == MODE_SDEC64) || (mode == MODE_SDEC32);
  endfunction

endpackage

@@ rtl/text_to_integer_parser.sv @@
// Top level of the text-to-integer parser: input register, mode register
// and the parse stage. Depends on ttip_pkg and ttip_parse.
//
// Characters arrive one per transaction with last_char on the final one; that
// transaction yields one result (status, value) and all others yield none.
// The block takes one character per cycle while the input is not stalled; a
// result reaches out_valid via the input register, parse stage and result
// register. The character sits in the input register while the parse stage
// works on it. That stage's per-character multiply-add and limit compare set
// the clock. The result register captures the result at the next edge. A
// result held while out_ready is low stalls the input only once the next last
// character reaches the parse stage. radix_mode selects signed decimal 64,
// unsigned decimal 64, hex 64, octal 64 or signed decimal 32, and must be
// written only while no string is in flight; the block does not enforce it.
module text_to_integer_parser import ttip_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  radix_mode,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_code,
  input  logic        last_char,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [63:0] value
);

  logic [2:0] mode;
  logic       buf_full;
  logic [7:0] buf_char;
  logic       buf_last;
  logic       buf_ready;
  logic       buf_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_SDEC64;
    end else if (cfg_valid && cfg_ready) begin
      mode <= radix_mode;
    end
  end

  assign buf_take = buf_full && buf_ready;
  assign in_ready = !buf_full || buf_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      buf_full <= 1'b1;
    end else if (buf_take) begin
      buf_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      buf_char <= char_code;
      buf_last <= last_char;
    end
  end

  ttip_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .mode       (mode),
    .item_valid (buf_full),
    .item_ready (buf_ready),
    .item_char  (buf_char),
    .item_last  (buf_last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .value      (value)
  );

endmodule

@@ rtl/ttip_step.sv @@
// Per-character step: digit decode, exact overflow check, accumulate,
// and final status/value for a string that ends on this character.
// Depends on ttip_pkg.
module ttip_step import ttip_pkg::*; (
  input  ttip_state_t state,
  input  logic [2:0]  mode,
  input  logic [7:0]  char_code,
  output ttip_state_t state_next,
  output status_t     status,
  output logic [63:0] value
);

  logic              is_sign;
  logic              dig_ok;
  logic [3:0]        dig;
  logic [WIDE_W-1:0] acc_wide;
  logic [WIDE_W-1:0] limit;
  logic [WIDE_W-1:0] cand;
  logic [ACC_W-1:0]  acc_hex;
  logic              ovf;

  assign is_sign  = (char_code == 8'h2b) || (char_code == 8'h2d);
  assign acc_wide = {4'b0000, state.acc};
  assign acc_hex  = {state.acc[ACC_W-5:0], dig};

  always_comb begin
    dig_ok = 1'b0;
    dig    = 4'd0;
    unique case (mode) inside
      MODE_SDEC64, MODE_UDEC64, MODE_SDEC32: begin
        dig_ok = (char_code >= 8'h30) && (char_code <= 8'h39);
        dig    = char_code[3:0];
      end
      MODE_OCT64: begin
        dig_ok = (char_code >= 8'h30) && (char_code <= 8'h37);
        dig    = char_code[3:0];
      end
      MODE_HEX64: begin
        if ((char_code >= 8'h30) && (char_code <= 8'h39)) begin
          dig_ok = 1'b1;
          dig    = char_code[3:0];
        end else if (((char_code >= 8'h61) && (char_code <= 8'h66)) ||
                     ((char_code >= 8'h41) && (char_code <= 8'h46))) begin
          dig_ok = 1'b1;
          dig    = char_code[3:0] + 4'd9;
        end
      end
      default: begin
        dig_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    unique case (mode)
      MODE_SDEC64: limit = {5'b0, {(ACC_W-1){1'b1}}} + {{(WIDE_W-1){1'b0}}, state.neg};
      MODE_SDEC32: limit = {{(WIDE_W-31){1'b0}}, {31{1'b1}}} +
                           {{(WIDE_W-1){1'b0}}, state.neg};
      default:     limit = {4'b0000, {ACC_W{1'b1}}};
    endcase
    if (mode == MODE_OCT64) begin
      cand = (acc_wide << 3) | {{(WIDE_W-4){1'b0}}, dig};
    end else begin
      cand = (acc_wide << 3) + (acc_wide << 1) + {{(WIDE_W-4){1'b0}}, dig};
    end
    ovf = (mode != MODE_HEX64) && (cand > limit);
  end

  always_comb begin
    state_next       = state;
    state_next.start = 1'b0;
    if (state.start && mode_signed(mode) && is_sign) begin
      state_next.neg = (char_code == 8'h2d);
    end else begin
      if (state.count != COUNT_MAX) begin
        state_next.count = state.count + 5'd1;
      end
      if (state.err == ST_OK) begin
        if (!dig_ok) begin
          state_next.err = ST_INVALID;
        end else if (ovf) begin
          state_next.err = ST_OVERFLOW;
        end else if (mode == MODE_HEX64) begin
          state_next.acc = acc_hex;
        end else begin
          state_next.acc = cand[ACC_W-1:0];
        end
      end
    end
  end

  always_comb begin
    if (state_next.count == 5'd0) begin
      status = ST_INVALID;
    end else if (state_next.count > mode_limit(mode)) begin
      status = ST_OVERFLOW;
    end else begin
      status = state_next.err;
    end
    if (status != ST_OK) begin
      value = '0;
    end else if (mode_signed(mode) && state_next.neg) begin
      value = '0 - state_next.acc;
    end else begin
      value = state_next.acc;
    end
  end

endmodule

@@ rtl/ttip_parse.sv @@
// Parse stage: per-string state registers and the result register.
// Depends on ttip_pkg and ttip_step.
module ttip_parse import ttip_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [2:0]  mode,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [7:0]  item_char,
  input  logic        item_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [63:0] value
);

  ttip_state_t state;
  ttip_state_t state_next;
  status_t     step_status;
  logic [63:0] step_value;
  logic        take;
  logic        out_full;
  status_t     out_status;
  logic [63:0] out_value;

  ttip_step u_step (
    .state      (state),
    .mode       (mode),
    .char_code  (item_char),
    .state_next (state_next),
    .status     (step_status),
    .value      (step_value)
  );

  assign item_ready = !item_last || !out_full || out_ready;
  assign take       = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_CLEAR;
    end else if (take) begin
      state <= item_last ? STATE_CLEAR : state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (take && item_last) begin
      out_full <= 1'b1;
    end else if (out_ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && item_last) begin
      out_status <= step_status;
      out_value  <= step_value;
    end
  end

  assign out_valid = out_full;
  assign status    = out_status;
  assign value     = out_value;

  a_start_clean: assert property (@(posedge clk) disable iff (rst)
    state.start |-> (state.count == 5'd0) && !state.neg && (state.err == ST_OK))
    else $error("string start with leftover state");

  a_count_acc: assert property (@(posedge clk) disable iff (rst)
    (state.count == 5'd0) |-> (state.acc == '0))
    else $error("accumulator nonzero with no digits");

  a_clear_on_last: assert property (@(posedge clk) disable iff (rst)
    take && item_last |=> state.start && (state.acc == '0))
    else $error("state not cleared after last character");

  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    out_full && (out_status != ST_OK) |-> (out_value == '0))
    else $error("nonzero value on failed parse");

endmodule
